// ===== rtl/a2e_pkg.sv =====
// Shared types, codes and tables for the ASN.1 time to epoch seconds core.
// No dependencies; every other file in rtl/ imports this package.
package a2e_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FORMAT = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_LOCAL  = 2'd3;

  // Day number of 1970-01-01 counted from 0000-01-01 (proleptic Gregorian).
  localparam int unsigned DAYS_TO_1970 = 719528;
  // Reciprocal of 100 scaled by 2^19, exact for the year range used here.
  localparam int unsigned RECIP_100 = 5243;
  localparam int unsigned SECS_PER_DAY = 86400;

  // Parser position inside the time string.
  typedef enum logic [4:0] {
    PH_Y0, PH_Y1, PH_Y2, PH_Y3,
    PH_MON0, PH_MON1, PH_DAY0, PH_DAY1,
    PH_HOUR0, PH_HOUR1, PH_MIN0, PH_MIN1,
    PH_SEC_OPT, PH_SEC2, PH_FRAC, PH_ZONE,
    PH_OFFH0, PH_OFFH1, PH_OFFM0, PH_OFFM1,
    PH_END, PH_STOP
  } phase_t;

  // One parsed string, handed from the parser to the converter.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        off_neg;
    logic [3:0]  off_hours;
    logic [5:0]  off_minutes;
    logic [1:0]  status;
  } rec_t;

  // Days in the year before the first day of the given month (non-leap).
  function automatic logic [8:0] cum_days(input logic [3:0] month);
    logic [8:0] r;
    case (month)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/a2e_front.sv =====
// Character parser: takes one character per beat and builds the field record.
// Depends on a2e_pkg.
module a2e_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    char_code,
  input  logic          time_kind,
  input  logic          last_char,
  output logic          push,
  output a2e_pkg::rec_t rec
);
  import a2e_pkg::*;

  phase_t      phase, phase_next;
  logic        kind, kind_next;
  logic [13:0] year, year_next;
  logic [6:0]  month, month_next, day, day_next, hour, hour_next;
  logic [6:0]  minute, minute_next, second, second_next;
  logic        off_neg, off_neg_next;
  logic [6:0]  off_h, off_h_next, off_m, off_m_next;
  logic [1:0]  err, err_next;
  logic        ended, ended_next;

  logic        dig, bad, ender, zone_bad;
  logic [3:0]  d;
  logic [6:0]  v;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_Y0; kind <= 1'b0; year <= '0; month <= '0; day <= '0;
      hour <= '0; minute <= '0; second <= '0; off_neg <= 1'b0;
      off_h <= '0; off_m <= '0; err <= ST_OK; ended <= 1'b0;
    end else begin
      phase <= phase_next; kind <= kind_next; year <= year_next;
      month <= month_next; day <= day_next; hour <= hour_next;
      minute <= minute_next; second <= second_next; off_neg <= off_neg_next;
      off_h <= off_h_next; off_m <= off_m_next; err <= err_next;
      ended <= ended_next;
    end
  end

  assign dig = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign d   = char_code[3:0];

  always_comb begin
    phase_next = phase; kind_next = kind; year_next = year;
    month_next = month; day_next = day; hour_next = hour;
    minute_next = minute; second_next = second; off_neg_next = off_neg;
    off_h_next = off_h; off_m_next = off_m; err_next = err;
    ended_next = ended; push = 1'b0; bad = 1'b0; v = '0; zone_bad = 1'b0;
    rec = '0;
    ender = 1'b0;
    if (accept) begin
      if (!ended) begin
        if (phase == PH_Y0) kind_next = time_kind;
        if (char_code == 8'h00) begin
          ended_next = 1'b1;
        end else begin
          unique case (phase)
            PH_Y0, PH_Y1, PH_Y2, PH_Y3: begin
              if (!dig) begin
                bad = 1'b1;
              end else begin
                year_next = 14'(year * 14'd10 + 14'(d));
                if (!kind_next && phase == PH_Y1) begin
                  year_next = year_next + ((year_next < 14'd50) ? 14'd2000 : 14'd1900);
                  phase_next = PH_MON0;
                end else begin
                  phase_next = phase_t'(phase + 5'd1);
                end
              end
            end
            PH_MON0: begin
              if (!dig) bad = 1'b1;
              else begin month_next = 7'(d); phase_next = PH_MON1; end
            end
            PH_MON1: begin
              v = 7'(month * 7'd10 + 7'(d));
              month_next = v;
              if (!dig || v < 7'd1 || v > 7'd12) bad = 1'b1;
              else phase_next = PH_DAY0;
            end
            PH_DAY0: begin
              if (!dig) bad = 1'b1;
              else begin day_next = 7'(d); phase_next = PH_DAY1; end
            end
            PH_DAY1: begin
              v = 7'(day * 7'd10 + 7'(d));
              day_next = v;
              if (!dig || v < 7'd1 || v > 7'd31) bad = 1'b1;
              else phase_next = PH_HOUR0;
            end
            PH_HOUR0: begin
              if (!dig) bad = 1'b1;
              else begin hour_next = 7'(d); phase_next = PH_HOUR1; end
            end
            PH_HOUR1: begin
              v = 7'(hour * 7'd10 + 7'(d));
              hour_next = v;
              if (!dig || v > 7'd23) bad = 1'b1;
              else phase_next = PH_MIN0;
            end
            PH_MIN0: begin
              if (!dig) bad = 1'b1;
              else begin minute_next = 7'(d); phase_next = PH_MIN1; end
            end
            PH_MIN1: begin
              v = 7'(minute * 7'd10 + 7'(d));
              minute_next = v;
              if (!dig || v > 7'd59) bad = 1'b1;
              else phase_next = PH_SEC_OPT;
            end
            PH_SEC_OPT, PH_FRAC: begin
              if (phase == PH_SEC_OPT && dig) begin
                second_next = 7'(d);
                phase_next = PH_SEC2;
              end else if (kind_next && (char_code == 8'h2E || char_code == 8'h2C || dig)) begin
                phase_next = PH_FRAC;
              end else begin
                zone_bad = 1'b1;
              end
            end
            PH_SEC2: begin
              v = 7'(second * 7'd10 + 7'(d));
              second_next = v;
              if (!dig || v > 7'd59) bad = 1'b1;
              else phase_next = kind_next ? PH_FRAC : PH_ZONE;
            end
            PH_ZONE: zone_bad = 1'b1;
            PH_OFFH0: begin
              if (!dig) bad = 1'b1;
              else begin off_h_next = 7'(d); phase_next = PH_OFFH1; end
            end
            PH_OFFH1: begin
              v = 7'(off_h * 7'd10 + 7'(d));
              off_h_next = v;
              if (!dig || v > 7'd12) bad = 1'b1;
              else phase_next = PH_OFFM0;
            end
            PH_OFFM0: begin
              if (!dig) bad = 1'b1;
              else begin off_m_next = 7'(d); phase_next = PH_OFFM1; end
            end
            PH_OFFM1: begin
              v = 7'(off_m * 7'd10 + 7'(d));
              off_m_next = v;
              if (!dig || v > 7'd59) bad = 1'b1;
              else phase_next = PH_END;
            end
            PH_END:  bad = 1'b1;
            PH_STOP: ;
            default: ;
          endcase
          // Zone designator: Z, or a sign that opens an hhmm offset.
          if (zone_bad) begin
            if (char_code == 8'h5A) begin
              phase_next = PH_END;
            end else if (char_code == 8'h2B || char_code == 8'h2D) begin
              off_neg_next = (char_code == 8'h2D);
              phase_next = PH_OFFH0;
            end else begin
              bad = 1'b1;
            end
          end
          if (bad) begin
            phase_next = PH_STOP;
            if (err == ST_OK) err_next = ST_FORMAT;
          end
        end
        // End of text: a zero byte or the final character.
        ender = (char_code == 8'h00) || last_char;
        if (ender && phase_next != PH_END && phase_next != PH_STOP) begin
          if (err_next == ST_OK) begin
            err_next = (phase_next == PH_FRAC || (phase_next == PH_SEC_OPT && kind_next))
                       ? ST_LOCAL : ST_FORMAT;
          end
          phase_next = PH_STOP;
        end
      end
      if (last_char) begin
        push = 1'b1;
        rec.year        = year_next;
        rec.month       = month_next[3:0];
        rec.day         = day_next[4:0];
        rec.hour        = hour_next[4:0];
        rec.minute      = minute_next[5:0];
        rec.second      = second_next[5:0];
        rec.off_neg     = off_neg_next;
        rec.off_hours   = off_h_next[3:0];
        rec.off_minutes = off_m_next[5:0];
        rec.status      = err_next;
        phase_next = PH_Y0; kind_next = 1'b0; year_next = '0; month_next = '0;
        day_next = '0; hour_next = '0; minute_next = '0; second_next = '0;
        off_neg_next = 1'b0; off_h_next = '0; off_m_next = '0;
        err_next = ST_OK; ended_next = 1'b0;
      end
    end
  end

endmodule

// ===== rtl/a2e_queue.sv =====
// Two-entry queue of parsed records between the parser and the converter.
// Depends on a2e_pkg.
module a2e_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  a2e_pkg::rec_t push_rec,
  input  logic          pop,
  output logic          head_valid,
  output a2e_pkg::rec_t head_rec,
  output logic          full
);
  import a2e_pkg::*;

  rec_t       entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_rec;
  end

  assign head_valid = (count != 2'd0);
  assign head_rec   = entry[rd_ptr];
  assign full       = (count == 2'd2);

endmodule

// ===== rtl/a2e_back.sv =====
// Four-stage conversion pipeline from a parsed record to signed epoch seconds,
// with the output register. Depends on a2e_pkg.
module a2e_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  a2e_pkg::rec_t      head_rec,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [38:0] epoch_seconds,
  output logic [1:0]         status
);
  import a2e_pkg::*;

  logic adv;
  logic v1, v2, v3, v4;

  // Stage 1 registers.
  logic [13:0] s1_year;
  logic [3:0]  s1_month;
  logic [4:0]  s1_day;
  logic [6:0]  s1_q100, s1_c100;
  logic [4:0]  s1_c400;
  logic [16:0] s1_tod;
  logic [9:0]  s1_off;
  logic        s1_neg;
  logic [1:0]  s1_st;
  // Stage 2 registers.
  logic signed [23:0] s2_days;
  logic               s2_leap, s2_ge1970;
  logic [3:0]         s2_month;
  logic [4:0]         s2_day;
  logic signed [18:0] s2_tod;
  logic [1:0]         s2_st;
  // Stage 3 registers.
  logic signed [23:0] s3_days;
  logic signed [18:0] s3_tod;
  logic               s3_ge1970;
  logic [1:0]         s3_st;
  // Stage 4 registers.
  logic signed [39:0] s4_secs;
  logic               s4_ge1970;
  logic [1:0]         s4_st;

  logic [27:0]        p_q100, p_c100, p_c400;
  logic [22:0]        y365;
  logic [23:0]        pos_days;
  logic [15:0]        off60;
  logic signed [41:0] prod;
  logic [1:0]         fin_st;

  assign adv = !out_valid || !out_stall;
  assign pop = adv && head_valid;

  assign p_q100 = 28'(head_rec.year) * 28'(RECIP_100);
  assign p_c100 = 28'(15'(head_rec.year) + 15'd99) * 28'(RECIP_100);
  assign p_c400 = 28'(15'(head_rec.year) + 15'd399) * 28'(RECIP_100);

  assign y365     = 23'(s1_year) * 23'd365;
  assign pos_days = 24'(y365) + 24'((15'(s1_year) + 15'd3) >> 2) + 24'(s1_c400)
                    - 24'(s1_c100);
  assign off60    = 16'(s1_off) * 16'd60;
  assign prod     = s3_days * $signed(18'(SECS_PER_DAY));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= head_valid; v2 <= v1; v3 <= v2; v4 <= v3; out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_year  <= head_rec.year;
      s1_month <= head_rec.month;
      s1_day   <= head_rec.day;
      s1_q100  <= p_q100[25:19];
      s1_c100  <= p_c100[25:19];
      s1_c400  <= p_c400[25:21];
      s1_tod   <= 17'(head_rec.hour) * 17'd3600 + 17'(head_rec.minute) * 17'd60
                  + 17'(head_rec.second);
      s1_off   <= 10'(head_rec.off_hours) * 10'd60 + 10'(head_rec.off_minutes);
      s1_neg   <= head_rec.off_neg;
      s1_st    <= head_rec.status;

      s2_days   <= $signed(pos_days) - $signed(24'(DAYS_TO_1970));
      s2_leap   <= (s1_year[1:0] == 2'b00)
                   && ((s1_year != 14'(s1_q100 * 14'd100)) || (s1_q100[1:0] == 2'b00));
      s2_ge1970 <= (s1_year >= 14'd1970);
      s2_month  <= s1_month;
      s2_day    <= s1_day;
      s2_tod    <= s1_neg ? $signed({2'b00, s1_tod}) + $signed({3'b000, off60})
                          : $signed({2'b00, s1_tod}) - $signed({3'b000, off60});
      s2_st     <= s1_st;

      s3_days   <= s2_days + $signed({15'd0, cum_days(s2_month)})
                   + $signed({23'd0, s2_leap && (s2_month > 4'd2)})
                   + $signed({19'd0, s2_day}) - 24'sd1;
      s3_tod    <= s2_tod;
      s3_ge1970 <= s2_ge1970;
      s3_st     <= s2_st;

      s4_secs   <= prod[39:0] + 40'(s3_tod);
      s4_ge1970 <= s3_ge1970;
      s4_st     <= s3_st;

      status        <= fin_st;
      epoch_seconds <= (fin_st == ST_OK) ? s4_secs[38:0] : '0;
    end
  end

  // Result sign must agree with the side of 1970 the year lies on.
  always_comb begin
    fin_st = s4_st;
    if (s4_st == ST_OK && (s4_ge1970 == s4_secs[39])) fin_st = ST_RANGE;
  end

endmodule

// ===== rtl/asn1_time_to_epoch_seconds_core.sv =====
// Top level of the ASN.1 time string to Unix epoch seconds core.
// Depends on a2e_pkg, a2e_front, a2e_queue and a2e_back.
//
//   Channel  Direction  Handshake           Beat payload
//   in       to core    in_valid/in_stall   char_code, time_kind, last_char
//   out      from core  out_valid/out_stall epoch_seconds, status
//
// Each character beat is parsed in the cycle it is accepted, so the core takes
// one beat per cycle while in_stall is low. The beat that carries last_char hands
// a parsed record to a two-entry queue; the converter turns it into seconds over
// four pipeline stages plus the output register. Reset (rst, synchronous)
// returns the parser to the start of a string and empties the queue and the
// pipeline. in_stall rises only while the queue is full; out_stall freezes the
// converter while out_valid is high, and the queue then fills.
module asn1_time_to_epoch_seconds_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_code,
  input  logic               time_kind,
  input  logic               last_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [38:0] epoch_seconds,
  output logic [1:0]         status
);
  import a2e_pkg::*;

  logic accept;
  logic push, pop, head_valid, q_full;
  rec_t push_rec, head_rec;

  // The parser may take a beat whenever the queue has room for a record.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  a2e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .time_kind (time_kind),
    .last_char (last_char),
    .push      (push),
    .rec       (push_rec)
  );

  a2e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .full       (q_full)
  );

  a2e_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_rec      (head_rec),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .epoch_seconds (epoch_seconds),
    .status        (status)
  );

  // A failed string always reports zero seconds.
  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> epoch_seconds == '0)
    else $error("nonzero seconds with error status");

  // The parser never hands a record to a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("record pushed into full queue");

  // The converter only takes records that are present.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("record popped from empty queue");

endmodule
